>>> rtl/core/tpfd_pkg.sv
// Tire-pressure frame decoder package: sync codes, frame byte positions,
// scale factors, alarm codes and the alarm priority function.
// No dependencies; used by the channel interfaces and the top level.
package tpfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 4;
    localparam int CODE_W     = 10;
    localparam int MBAR_W     = 15;
    localparam int PSI_W      = 18;
    localparam int TEMP_W     = 9;
    localparam int ALARM_W    = 3;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hA1;

    localparam logic [POS_W-1:0] POS_IDLE      = 4'd0;
    localparam logic [POS_W-1:0] POS_FIRST     = 4'd2;
    localparam logic [POS_W-1:0] POS_SENSOR_ID = 4'd5;
    localparam logic [POS_W-1:0] POS_PRESS_HI  = 4'd9;
    localparam logic [POS_W-1:0] POS_PRESS_LO  = 4'd10;
    localparam logic [POS_W-1:0] POS_TEMP      = 4'd11;
    localparam logic [POS_W-1:0] POS_STATUS    = 4'd12;
    localparam logic [POS_W-1:0] POS_LAST      = 4'd13;

    localparam logic [MBAR_W-1:0] MBAR_PER_CODE     = 15'd25;
    localparam logic [PSI_W-1:0]  PSI_Q400_PER_CODE = 18'd145;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET       = 9'd50;

    localparam logic [BYTE_W-1:0] SENSOR_MIN = 8'd1;
    localparam logic [BYTE_W-1:0] SENSOR_MAX = 8'd4;

    typedef enum logic [ALARM_W-1:0] {
        ALARM_NONE      = 3'd0,
        ALARM_FAST_LEAK = 3'd1,
        ALARM_HIGH_PRES = 3'd2,
        ALARM_LOW_PRES  = 3'd3,
        ALARM_HIGH_TEMP = 3'd4,
        ALARM_LOW_BATT  = 3'd5
    } alarm_t;

    function automatic alarm_t alarm_of(input logic [BYTE_W-1:0] status);
        alarm_t a;
        if (status[1:0] == 2'b01)
            a = ALARM_FAST_LEAK;
        else if (status[4])
            a = ALARM_HIGH_PRES;
        else if (status[3])
            a = ALARM_LOW_PRES;
        else if (status[2])
            a = ALARM_HIGH_TEMP;
        else if (status[7])
            a = ALARM_LOW_BATT;
        else
            a = ALARM_NONE;
        return a;
    endfunction

endpackage

>>> rtl/core/tpfd_rx_if.sv
// Byte channel into the tire-pressure frame decoder: valid, ready, rx_byte.
// Depends on tpfd_pkg for the byte width.
interface tpfd_rx_if import tpfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/tpfd_rec_if.sv
// Record channel out of the tire-pressure frame decoder: valid, ready and
// the decoded frame fields. Depends on tpfd_pkg for the field widths.
interface tpfd_rec_if import tpfd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [BYTE_W-1:0]         sensor_id;
    logic                      known_sensor;
    logic [CODE_W-1:0]         pressure_code;
    logic [MBAR_W-1:0]         pressure_mbar;
    logic [PSI_W-1:0]          pressure_psi_q400;
    logic signed [TEMP_W-1:0]  temperature_c;
    logic [ALARM_W-1:0]        alarm;

    modport source (output valid, output sensor_id, output known_sensor,
                    output pressure_code, output pressure_mbar,
                    output pressure_psi_q400, output temperature_c,
                    output alarm, input ready);
    modport sink   (input valid, input sensor_id, input known_sensor,
                    input pressure_code, input pressure_mbar,
                    input pressure_psi_q400, input temperature_c,
                    input alarm, output ready);
endinterface

>>> rtl/core/tire_pressure_frame_decoder.sv
// Tire-pressure frame decoder top level: sync hunt, field capture and
// record build. Depends on tpfd_pkg, tpfd_rx_if and tpfd_rec_if.
//
//   channel  dir  word                     results per word
//   rx       in   rx_byte                  0 or 1
//   rec      out  decoded frame record     -
//
// One byte per cycle; a record leaves the output register the cycle after
// the last frame byte is taken. Reset clears sync, frame and output state.
// While a record waits, bytes keep flowing unless the next one could end a
// frame; that byte stalls until the record is taken.
module tire_pressure_frame_decoder import tpfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tpfd_rx_if.sink      rx,
    tpfd_rec_if.source   rec
);

    logic              sync_pending_reg, sync_pending_next;
    logic              in_frame_reg, in_frame_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] sensor_id_reg, sensor_id_next;
    logic [1:0]        press_hi_reg, press_hi_next;
    logic [BYTE_W-1:0] press_lo_reg, press_lo_next;
    logic [BYTE_W-1:0] temp_reg, temp_next;
    logic [BYTE_W-1:0] status_reg, status_next;
    logic              out_valid_reg, out_valid_next;

    logic [BYTE_W-1:0]        out_id_reg;
    logic                     out_known_reg;
    logic [CODE_W-1:0]        out_code_reg;
    logic [MBAR_W-1:0]        out_mbar_reg;
    logic [PSI_W-1:0]         out_psi_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;
    alarm_t                   out_alarm_reg;

    logic              accept;
    logic              emit;
    logic              may_emit;
    logic [CODE_W-1:0] code;

    assign may_emit = in_frame_reg && (pos_reg == POS_LAST);
    assign rx.ready = !out_valid_reg || rec.ready || !may_emit;
    assign accept   = rx.valid && rx.ready;
    assign code     = {press_hi_reg, press_lo_reg};

    always_comb
    begin
        sync_pending_next = sync_pending_reg;
        in_frame_next     = in_frame_reg;
        pos_next          = pos_reg;
        sensor_id_next    = sensor_id_reg;
        press_hi_next     = press_hi_reg;
        press_lo_next     = press_lo_reg;
        temp_next         = temp_reg;
        status_next       = status_reg;
        emit              = 1'b0;
        if (accept)
        begin
            if (rx.rx_byte == SYNC_FIRST)
            begin
                sync_pending_next = 1'b1;
            end
            else if (sync_pending_reg && rx.rx_byte == SYNC_SECOND)
            begin
                sync_pending_next = 1'b0;
                in_frame_next     = 1'b1;
                pos_next          = POS_FIRST;
            end
            else
            begin
                sync_pending_next = 1'b0;
                if (in_frame_reg)
                begin
                    unique case (pos_reg)
                        POS_SENSOR_ID: sensor_id_next = rx.rx_byte;
                        POS_PRESS_HI:  press_hi_next  = rx.rx_byte[1:0];
                        POS_PRESS_LO:  press_lo_next  = rx.rx_byte;
                        POS_TEMP:      temp_next      = rx.rx_byte;
                        POS_STATUS:    status_next    = rx.rx_byte;
                        default:       ;
                    endcase
                    if (pos_reg == POS_LAST)
                    begin
                        in_frame_next = 1'b0;
                        pos_next      = POS_IDLE;
                        emit          = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
        end
        if (emit)
            out_valid_next = 1'b1;
        else if (rec.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_pending_reg <= 1'b0;
            in_frame_reg     <= 1'b0;
            pos_reg          <= POS_IDLE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            sync_pending_reg <= sync_pending_next;
            in_frame_reg     <= in_frame_next;
            pos_reg          <= pos_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sensor_id_reg <= sensor_id_next;
        press_hi_reg  <= press_hi_next;
        press_lo_reg  <= press_lo_next;
        temp_reg      <= temp_next;
        status_reg    <= status_next;
        if (emit)
        begin
            out_id_reg    <= sensor_id_reg;
            out_known_reg <= (sensor_id_reg >= SENSOR_MIN) && (sensor_id_reg <= SENSOR_MAX);
            out_code_reg  <= code;
            out_mbar_reg  <= MBAR_W'(code) * MBAR_PER_CODE;
            out_psi_reg   <= PSI_W'(code) * PSI_Q400_PER_CODE;
            out_temp_reg  <= signed'({1'b0, temp_reg} - TEMP_OFFSET);
            out_alarm_reg <= alarm_of(status_reg);
        end
    end

    assign rec.valid             = out_valid_reg;
    assign rec.sensor_id         = out_id_reg;
    assign rec.known_sensor      = out_known_reg;
    assign rec.pressure_code     = out_code_reg;
    assign rec.pressure_mbar     = out_mbar_reg;
    assign rec.pressure_psi_q400 = out_psi_reg;
    assign rec.temperature_c     = out_temp_reg;
    assign rec.alarm             = out_alarm_reg;

endmodule
